### rtl/core/bsc_pkg.sv
// Shared constants, codes and types of the banker's safety check block.
// Used by the channel interfaces, the arithmetic unit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

	// Default sizing of the process table and of the amounts.
	localparam int MAX_PROCS_DEF   = 16;
	localparam int AMOUNT_BITS_DEF = 16;

	// Fixed widths of the channel fields.
	localparam int TYPE_W  = 2;
	localparam int PIDX_W  = 4;
	localparam int FIELD_W = 16;
	localparam int ID_W    = 4;

	// Operation codes carried in req_type.
	typedef enum logic [TYPE_W-1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_APPEND = 2'd1,
		REQ_CHECK  = 2'd2,
		REQ_TEST   = 2'd3
	} req_type_t;

	// Codes carried in result_kind.
	localparam logic KIND_ORDER   = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM_RD,
		ST_SUM_ACC,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_EMIT_RD,
		ST_EMIT_LOAD,
		ST_VERDICT
	} state_t;

	// Control of the shared arithmetic unit.
	typedef struct packed {
		logic sub;   // subtract the holding from free rather than add it
		logic bump;  // the entry under test carries the requested extra units
	} unit_op_t;

endpackage

`default_nettype wire

### rtl/core/bsc_ifs.sv
// Valid/ready channel interfaces: request items, result items and the
// configuration write channel. Depends on bsc_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bsc_req_if;
	logic                         valid;
	logic                         ready;
	logic [bsc_pkg::TYPE_W-1:0]   req_type;
	logic [bsc_pkg::PIDX_W-1:0]   proc_index;
	logic [bsc_pkg::FIELD_W-1:0]  alloc_amount;
	logic [bsc_pkg::FIELD_W-1:0]  max_amount;
	logic [bsc_pkg::FIELD_W-1:0]  request_amount;

	modport source (output valid, req_type, proc_index, alloc_amount, max_amount,
		request_amount, input ready);
	modport sink (input valid, req_type, proc_index, alloc_amount, max_amount,
		request_amount, output ready);
endinterface

interface bsc_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       result_kind;
	logic [bsc_pkg::ID_W-1:0]   proc_id;
	logic                       safe;
	logic                       last;

	modport source (output valid, result_kind, proc_id, safe, last, input ready);
	modport sink (input valid, result_kind, proc_id, safe, last, output ready);
endinterface

interface bsc_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [bsc_pkg::FIELD_W-1:0]  data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

### rtl/core/bsc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bsc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/bsc_unit.sv
// Shared add/compare unit of the safety check: folds one holding into the
// free count and tests whether an entry's remaining need fits. Uses bsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsc_unit #(
	parameter int STORE_W = 16,
	parameter int FREE_W  = 23
) (
	input  wire bsc_pkg::unit_op_t      op,
	input  wire logic signed [FREE_W-1:0] free_in,
	input  wire logic [STORE_W-1:0]     alloc,
	input  wire logic [STORE_W-1:0]     claim,
	input  wire logic [STORE_W-1:0]     bump_amt,
	output logic signed [FREE_W-1:0]    sum,
	output logic                        fits
);
	import bsc_pkg::*;

	logic [STORE_W:0]          held;
	logic signed [FREE_W-1:0]  held_ext;
	logic signed [FREE_W-1:0]  claim_ext;

	always_comb begin
		held      = {1'b0, alloc} + (op.bump ? {1'b0, bump_amt} : '0);
		held_ext  = $signed({{(FREE_W-STORE_W-1){1'b0}}, held});
		claim_ext = $signed({{(FREE_W-STORE_W){1'b0}}, claim});
		sum       = op.sub ? (free_in - held_ext) : (free_in + held_ext);
		// claim - held <= free is the same test as claim <= free + held.
		fits      = (claim_ext <= sum);
	end

endmodule

`default_nettype wire

### rtl/core/bankers_safety_check_top.sv
// Top level of the banker's safety check for a single resource type.
// Depends on bsc_pkg, the channel interfaces, bsc_ram and bsc_unit.
//
//   Channel | Dir | Fields                                         | Transfer when
//   req     | in  | req_type proc_index alloc/max/request_amount   | req.valid & req.ready
//   rsp     | out | result_kind proc_id safe last                  | rsp.valid & rsp.ready
//   cfg     | in  | data (total_resources)                         | cfg.valid & cfg.ready
//
// Clear and append complete in the idle state that accepts them. A check over n
// entries first sums the holdings of all entries and then scans with restarts;
// each step reads an entry through the registered read of the process table RAM
// feeding the one shared add/compare unit. A request test runs up to two passes.
// The order of a safe check leaves one entry at a time from the order RAM, each
// loaded into the output register once free. Reset is asynchronous and clears the
// entry count, the finished flags and the total; the table needs no clearing pass.
// The request side is ready only between operations, whilst a finished result may
// still sit in the output register waiting for its transfer.
`timescale 1ns / 1ps
`default_nettype none

module bankers_safety_check_top #(
	parameter int MAX_PROCS   = bsc_pkg::MAX_PROCS_DEF,
	parameter int AMOUNT_BITS = bsc_pkg::AMOUNT_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	bsc_req_if.sink    req,
	bsc_rsp_if.source  rsp,
	bsc_cfg_if.sink    cfg
);
	import bsc_pkg::*;

	// Amounts are kept at the masked width only.
	localparam int STORE_W = (AMOUNT_BITS < FIELD_W) ? AMOUNT_BITS : FIELD_W;
	localparam int IDX_W   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CNT_W   = $clog2(MAX_PROCS + 1);
	// Free can fall to minus the sum of all holdings plus one request.
	localparam int FREE_W  = STORE_W + CNT_W + 2;
	localparam int CMP_W   = (CNT_W > PIDX_W) ? CNT_W : PIDX_W;

	// Sequencer and datapath registers.
	state_t                    state_q, state_d;
	logic [CNT_W-1:0]          count_q, count_d;
	logic [CNT_W-1:0]          done_q, done_d;
	logic [IDX_W-1:0]          scan_q, scan_d;
	logic [MAX_PROCS-1:0]      flags_q, flags_d;
	req_type_t                 op_q, op_d;
	logic                      pass2_q, pass2_d;
	logic                      verdict_q, verdict_d;
	logic [STORE_W-1:0]        total_q;
	logic signed [FREE_W-1:0]  free_q, free_d;
	logic [IDX_W-1:0]          bump_idx_q, bump_idx_d;
	logic [STORE_W-1:0]        amt_q, amt_d;

	// Output register.
	logic              rsp_valid_q, rsp_valid_d;
	logic              rsp_kind_q, rsp_kind_d;
	logic [ID_W-1:0]   rsp_id_q, rsp_id_d;
	logic              rsp_safe_q, rsp_safe_d;
	logic              rsp_last_q, rsp_last_d;

	// Memory and unit connections.
	logic                      tbl_we, tbl_re;
	logic [2*STORE_W-1:0]      tbl_wdata, tbl_rdata;
	logic                      ord_we, ord_re;
	logic [IDX_W-1:0]          ord_rdata;
	unit_op_t                  uop;
	logic signed [FREE_W-1:0]  unit_sum;
	logic                      unit_fits;

	logic accept, out_free, scan_last, finish, finish_safe;

	assign req.ready   = (state_q == ST_IDLE);
	assign cfg.ready   = 1'b1;
	assign accept      = req.valid && req.ready;
	assign out_free    = !rsp_valid_q || rsp.ready;
	assign scan_last   = (CNT_W'(scan_q) + CNT_W'(1)) == count_q;
	assign tbl_wdata   = {req.max_amount[STORE_W-1:0], req.alloc_amount[STORE_W-1:0]};

	assign rsp.valid       = rsp_valid_q;
	assign rsp.result_kind = rsp_kind_q;
	assign rsp.proc_id     = rsp_id_q;
	assign rsp.safe        = rsp_safe_q;
	assign rsp.last        = rsp_last_q;

	// Allocation (low half) and claim (high half) of every entry.
	bsc_ram #(
		.WIDTH (2*STORE_W),
		.DEPTH (MAX_PROCS)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (IDX_W'(count_q)),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (scan_q),
		.rdata (tbl_rdata)
	);

	// Finishing order of the last pass.
	bsc_ram #(
		.WIDTH (IDX_W),
		.DEPTH (MAX_PROCS)
	) u_ord_ram (
		.clk   (clk),
		.we    (ord_we),
		.waddr (IDX_W'(done_q)),
		.wdata (scan_q),
		.re    (ord_re),
		.raddr (scan_q),
		.rdata (ord_rdata)
	);

	bsc_unit #(
		.STORE_W (STORE_W),
		.FREE_W  (FREE_W)
	) u_unit (
		.op       (uop),
		.free_in  (free_q),
		.alloc    (tbl_rdata[STORE_W-1:0]),
		.claim    (tbl_rdata[2*STORE_W-1:STORE_W]),
		.bump_amt (amt_q),
		.sum      (unit_sum),
		.fits     (unit_fits)
	);

	// Next state and datapath control.
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		done_d      = done_q;
		scan_d      = scan_q;
		flags_d     = flags_q;
		op_d        = op_q;
		pass2_d     = pass2_q;
		verdict_d   = verdict_q;
		free_d      = free_q;
		bump_idx_d  = bump_idx_q;
		amt_d       = amt_q;
		rsp_valid_d = rsp_valid_q && !rsp.ready;
		rsp_kind_d  = rsp_kind_q;
		rsp_id_d    = rsp_id_q;
		rsp_safe_d  = rsp_safe_q;
		rsp_last_d  = rsp_last_q;
		tbl_we      = 1'b0;
		tbl_re      = 1'b0;
		ord_we      = 1'b0;
		ord_re      = 1'b0;
		finish      = 1'b0;
		finish_safe = 1'b0;
		// The entry under test gets its extra units only in the second pass.
		uop.sub     = (state_q == ST_SUM_ACC);
		uop.bump    = pass2_q && (scan_q == bump_idx_q);

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req_type_t'(req.req_type))
						REQ_CLEAR: begin
							count_d = '0;
							done_d  = '0;
						end
						REQ_APPEND: begin
							// A full table drops the entry.
							if (count_q < CNT_W'(MAX_PROCS)) begin
								tbl_we  = 1'b1;
								count_d = count_q + CNT_W'(1);
							end
						end
						REQ_CHECK: begin
							op_d    = REQ_CHECK;
							pass2_d = 1'b0;
							if (count_q == '0) begin
								// An empty table is safe and has no order.
								verdict_d = 1'b1;
								state_d   = ST_VERDICT;
							end else begin
								free_d  = $signed({{(FREE_W-STORE_W){1'b0}}, total_q});
								flags_d = '0;
								scan_d  = '0;
								done_d  = '0;
								state_d = ST_SUM_RD;
							end
						end
						REQ_TEST: begin
							op_d       = REQ_TEST;
							pass2_d    = 1'b0;
							bump_idx_d = IDX_W'(req.proc_index);
							amt_d      = req.request_amount[STORE_W-1:0];
							if (CMP_W'(req.proc_index) >= CMP_W'(count_q)) begin
								// The named entry is not in the table.
								verdict_d = 1'b0;
								state_d   = ST_VERDICT;
							end else begin
								free_d  = $signed({{(FREE_W-STORE_W){1'b0}}, total_q});
								flags_d = '0;
								scan_d  = '0;
								done_d  = '0;
								state_d = ST_SUM_RD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_SUM_RD: begin
				tbl_re  = 1'b1;
				state_d = ST_SUM_ACC;
			end
			ST_SUM_ACC: begin
				free_d = unit_sum;
				if (scan_last) begin
					scan_d  = '0;
					state_d = ST_SCAN_RD;
				end else begin
					scan_d  = scan_q + IDX_W'(1);
					state_d = ST_SUM_RD;
				end
			end
			ST_SCAN_RD: begin
				tbl_re  = 1'b1;
				state_d = ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				if (!flags_q[scan_q] && unit_fits) begin
					free_d          = unit_sum;
					flags_d[scan_q] = 1'b1;
					ord_we          = 1'b1;
					done_d          = done_q + CNT_W'(1);
					scan_d          = '0;
					if ((done_q + CNT_W'(1)) == count_q) begin
						finish      = 1'b1;
						finish_safe = 1'b1;
					end else begin
						state_d = ST_SCAN_RD;
					end
				end else if (scan_last) begin
					// A full sweep found nothing that can finish.
					finish      = 1'b1;
					finish_safe = 1'b0;
				end else begin
					scan_d  = scan_q + IDX_W'(1);
					state_d = ST_SCAN_RD;
				end
			end
			ST_EMIT_RD: begin
				ord_re  = 1'b1;
				state_d = ST_EMIT_LOAD;
			end
			ST_EMIT_LOAD: begin
				if (out_free) begin
					rsp_valid_d = 1'b1;
					rsp_kind_d  = KIND_ORDER;
					rsp_id_d    = ID_W'(ord_rdata);
					rsp_safe_d  = 1'b0;
					rsp_last_d  = 1'b0;
					if ((CNT_W'(scan_q) + CNT_W'(1)) == done_q) begin
						verdict_d = 1'b1;
						state_d   = ST_VERDICT;
					end else begin
						scan_d  = scan_q + IDX_W'(1);
						state_d = ST_EMIT_RD;
					end
				end
			end
			ST_VERDICT: begin
				if (out_free) begin
					rsp_valid_d = 1'b1;
					rsp_kind_d  = KIND_VERDICT;
					rsp_id_d    = '0;
					rsp_safe_d  = verdict_q;
					rsp_last_d  = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// End of a pass: start the changed-state pass of a request test, list the
		// order of a safe check, or give the verdict.
		if (finish) begin
			if ((op_q == REQ_TEST) && !pass2_q && finish_safe) begin
				pass2_d = 1'b1;
				free_d  = $signed({{(FREE_W-STORE_W){1'b0}}, total_q});
				flags_d = '0;
				scan_d  = '0;
				done_d  = '0;
				state_d = ST_SUM_RD;
			end else if ((op_q == REQ_CHECK) && finish_safe) begin
				scan_d  = '0;
				state_d = ST_EMIT_RD;
			end else begin
				verdict_d = finish_safe;
				state_d   = ST_VERDICT;
			end
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			done_q      <= '0;
			scan_q      <= '0;
			flags_q     <= '0;
			op_q        <= REQ_CLEAR;
			pass2_q     <= 1'b0;
			verdict_q   <= 1'b0;
			total_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			done_q      <= done_d;
			scan_q      <= scan_d;
			flags_q     <= flags_d;
			op_q        <= op_d;
			pass2_q     <= pass2_d;
			verdict_q   <= verdict_d;
			rsp_valid_q <= rsp_valid_d;
			if (cfg.valid && cfg.ready) begin
				total_q <= cfg.data[STORE_W-1:0];
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		free_q     <= free_d;
		bump_idx_q <= bump_idx_d;
		amt_q      <= amt_d;
		rsp_kind_q <= rsp_kind_d;
		rsp_id_q   <= rsp_id_d;
		rsp_safe_q <= rsp_safe_d;
		rsp_last_q <= rsp_last_d;
	end

	// The number of finished entries can never pass the number of entries in the table.
	a_done_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		done_q <= count_q)
		else $error("finished count exceeds entry count");

	a_count_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_PROCS))
		else $error("entry count exceeds table size");

	// Whilst a pass walks the table its index stays inside the filled part.
	a_scan_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM_RD || state_q == ST_SUM_ACC || state_q == ST_SCAN_RD ||
		 state_q == ST_SCAN_CMP) |-> (CNT_W'(scan_q) < count_q))
		else $error("scan index outside the table");

	// Order entries never close an operation and never carry a verdict.
	a_order_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_kind_q == KIND_ORDER) |-> (!rsp_safe_q && !rsp_last_q))
		else $error("order entry with verdict or last set");

	// Emitting the order only ever follows a complete, safe pass.
	a_emit_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_RD) |-> (done_q == count_q))
		else $error("order emitted from an incomplete pass");

endmodule

`default_nettype wire
